// ===== hw/rtl/lavm_pkg.sv =====
// Shared types, constants and helpers of the look-at view matrix block.
package lavm_pkg;

    localparam int NORM_W = 31;
    localparam int ROOT_W = 32;
    localparam int SUMSQ_W = 64;
    localparam int SAT_W = 40;
    localparam int EYE_W = 32;
    localparam int COL_W = 32;

    typedef enum logic [1:0] {
        ROW_SIDE,
        ROW_UP,
        ROW_FWD,
        ROW_CONST
    } row_t;

    function automatic logic signed [COL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [COL_W-1:0] r;
        if (&x[SAT_W-1:COL_W-1] || ~|x[SAT_W-1:COL_W-1])
        begin
            r = x[COL_W-1:0];
        end
        else if (x[SAT_W-1])
        begin
            r = {1'b1, {(COL_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/look_at_view_matrix.sv =====
// Top level of the look-at view matrix block.
//
// Usage: drive eye, focus and up (signed, FRAC_BITS fraction bits) and raise
// start; the transfer happens at a clock edge with start high and busy low.
// busy then goes high, and no new item enters until it falls again.
// Each item produces four row transfers on consecutive cycles, each marked by
// row_strobe for one cycle: side, up, negated forward, then the constant row
// (row_last high). degenerate is the same on all four rows.
// The path from the start transfer to the first row runs through two
// normalizer pipelines in series, each a bit-per-stage square root and
// divider chain. Input pacing by busy fits the four-row result channel.
// The receiver cannot stall; the rows of one item never overlap the next.
// Reset clears all valid bits and the row sequencer; no rows are in flight.
module look_at_view_matrix import lavm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      eye_x,
    input  logic signed [31:0]      eye_y,
    input  logic signed [31:0]      eye_z,
    input  logic signed [31:0]      focus_x,
    input  logic signed [31:0]      focus_y,
    input  logic signed [31:0]      focus_z,
    input  logic signed [31:0]      up_x,
    input  logic signed [31:0]      up_y,
    input  logic signed [31:0]      up_z,
    output logic                    row_strobe,
    output logic [1:0]              row_index,
    output logic signed [31:0]      col0,
    output logic signed [31:0]      col1,
    output logic signed [31:0]      col2,
    output logic signed [31:0]      col3,
    output logic                    degenerate,
    output logic                    row_last
);

    localparam int CW = FRAC_BITS + 2;
    localparam int FVW = EYE_W + 1;
    localparam int PW = 2 * CW;
    localparam int SRW = PW + 1;
    localparam int UW = FRAC_BITS + 3;
    localparam int EPW = CW + EYE_W;
    localparam int UPW = UW + EYE_W;
    localparam int DOTW = 38;
    localparam int DSW = FRAC_BITS + DOTW;
    localparam int EBW = 3 * EYE_W;
    localparam int SBC = 3 * CW + EBW + 1;
    localparam logic signed [DSW-1:0] DHALF =
        {{(DSW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [SRW-1:0] UHALF =
        {{(SRW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [COL_W-1:0] ONE =
        {{(COL_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // input slot pacing
    logic [1:0] gap_reg;
    logic [1:0] gap_next;
    logic       accept;

    assign accept = start && (gap_reg == 2'd0);
    assign busy   = (gap_reg != 2'd0);

    always_comb
    begin
        if (accept)
        begin
            gap_next = 2'd3;
        end
        else if (gap_reg != 2'd0)
        begin
            gap_next = gap_reg - 2'd1;
        end
        else
        begin
            gap_next = gap_reg;
        end
    end

    logic                   in_v_reg;
    logic signed [FVW-1:0]  fw_reg  [3];
    logic signed [FVW-1:0]  up_reg  [3];
    logic signed [EYE_W-1:0] eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg  <= 2'd0;
            in_v_reg <= 1'b0;
        end
        else
        begin
            gap_reg  <= gap_next;
            in_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fw_reg[0]  <= FVW'(focus_x) - FVW'(eye_x);
            fw_reg[1]  <= FVW'(focus_y) - FVW'(eye_y);
            fw_reg[2]  <= FVW'(focus_z) - FVW'(eye_z);
            up_reg[0]  <= FVW'(up_x);
            up_reg[1]  <= FVW'(up_y);
            up_reg[2]  <= FVW'(up_z);
            eye_reg[0] <= eye_x;
            eye_reg[1] <= eye_y;
            eye_reg[2] <= eye_z;
        end
    end

    // forward and up normalizers
    logic                 a_v;
    logic signed [CW-1:0] f_a  [3];
    logic signed [CW-1:0] u0_a [3];
    logic                 okf_a;
    logic [EBW-1:0]       eye_a;

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .VW        (FVW),
        .SBW       (1)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_v_reg),
        .in_vec    (fw_reg),
        .in_sb     (1'b0),
        .out_valid (a_v),
        .out_vec   (f_a),
        .out_nz    (okf_a),
        .out_sb    ()
    );

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .VW        (FVW),
        .SBW       (EBW)
    ) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_v_reg),
        .in_vec    (up_reg),
        .in_sb     ({eye_reg[2], eye_reg[1], eye_reg[0]}),
        .out_valid (),
        .out_vec   (u0_a),
        .out_nz    (),
        .out_sb    (eye_a)
    );

    // side = forward x up
    logic                 x1_v_reg;
    logic signed [PW-1:0] px_reg [6];
    logic signed [CW-1:0] x1_f_reg [3];
    logic [EBW-1:0]       x1_eye_reg;
    logic                 x1_okf_reg;

    logic                  x2_v_reg;
    logic signed [SRW-1:0] sr_reg [3];
    logic signed [CW-1:0]  x2_f_reg [3];
    logic [EBW-1:0]        x2_eye_reg;
    logic                  x2_okf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_v_reg <= 1'b0;
            x2_v_reg <= 1'b0;
        end
        else
        begin
            x1_v_reg <= a_v;
            x2_v_reg <= x1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg[0]  <= f_a[1] * u0_a[2];
        px_reg[1]  <= f_a[2] * u0_a[1];
        px_reg[2]  <= f_a[2] * u0_a[0];
        px_reg[3]  <= f_a[0] * u0_a[2];
        px_reg[4]  <= f_a[0] * u0_a[1];
        px_reg[5]  <= f_a[1] * u0_a[0];
        x1_f_reg   <= f_a;
        x1_eye_reg <= eye_a;
        x1_okf_reg <= okf_a;
        for (int i = 0; i < 3; i++)
        begin
            sr_reg[i] <= SRW'(px_reg[2*i]) - SRW'(px_reg[2*i+1]);
        end
        x2_f_reg   <= x1_f_reg;
        x2_eye_reg <= x1_eye_reg;
        x2_okf_reg <= x1_okf_reg;
    end

    // side normalizer
    logic                 c_v;
    logic signed [CW-1:0] s_c [3];
    logic                 oks_c;
    logic [SBC-1:0]       c_sb;

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .VW        (SRW),
        .SBW       (SBC)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x2_v_reg),
        .in_vec    (sr_reg),
        .in_sb     ({x2_f_reg[2], x2_f_reg[1], x2_f_reg[0], x2_eye_reg, x2_okf_reg}),
        .out_valid (c_v),
        .out_vec   (s_c),
        .out_nz    (oks_c),
        .out_sb    (c_sb)
    );

    logic signed [CW-1:0]    f_c   [3];
    logic signed [EYE_W-1:0] eye_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f_c[i]   = c_sb[1 + EBW + i*CW +: CW];
            eye_c[i] = c_sb[1 + i*EYE_W +: EYE_W];
        end
    end

    // products, true up, dot products
    logic                    d1_v_reg;
    logic signed [PW-1:0]    psf_reg [6];
    logic signed [EPW-1:0]   pse_reg [3];
    logic signed [EPW-1:0]   pfe_reg [3];
    logic signed [CW-1:0]    d1_s_reg [3];
    logic signed [CW-1:0]    d1_f_reg [3];
    logic signed [EYE_W-1:0] d1_eye_reg [3];
    logic                    d1_deg_reg;

    logic                    d2_v_reg;
    logic signed [UW-1:0]    d2_u_reg [3];
    logic signed [DOTW-1:0]  d2_ds_reg;
    logic signed [DOTW-1:0]  d2_df_reg;
    logic signed [CW-1:0]    d2_s_reg [3];
    logic signed [CW-1:0]    d2_f_reg [3];
    logic signed [EYE_W-1:0] d2_eye_reg [3];
    logic                    d2_deg_reg;

    logic                    d3_v_reg;
    logic signed [UPW-1:0]   pue_reg [3];
    logic signed [UW-1:0]    d3_u_reg [3];
    logic signed [DOTW-1:0]  d3_ds_reg;
    logic signed [DOTW-1:0]  d3_df_reg;
    logic signed [CW-1:0]    d3_s_reg [3];
    logic signed [CW-1:0]    d3_f_reg [3];
    logic                    d3_deg_reg;

    logic                    d4_v_reg;
    logic signed [DOTW-1:0]  d4_du_reg;
    logic signed [UW-1:0]    d4_u_reg [3];
    logic signed [DOTW-1:0]  d4_ds_reg;
    logic signed [DOTW-1:0]  d4_df_reg;
    logic signed [CW-1:0]    d4_s_reg [3];
    logic signed [CW-1:0]    d4_f_reg [3];
    logic                    d4_deg_reg;

    logic signed [SRW-1:0]   u_sum [3];
    logic signed [DSW-1:0]   ds_sum;
    logic signed [DSW-1:0]   df_sum;
    logic signed [DSW-1:0]   du_sum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_sum[i] = SRW'(psf_reg[2*i]) - SRW'(psf_reg[2*i+1]) + UHALF;
        end
        ds_sum = DSW'(pse_reg[0]) + DSW'(pse_reg[1]) + DSW'(pse_reg[2]) + DHALF;
        df_sum = DSW'(pfe_reg[0]) + DSW'(pfe_reg[1]) + DSW'(pfe_reg[2]) + DHALF;
        du_sum = DSW'(pue_reg[0]) + DSW'(pue_reg[1]) + DSW'(pue_reg[2]) + DHALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
            d3_v_reg <= 1'b0;
            d4_v_reg <= 1'b0;
        end
        else
        begin
            d1_v_reg <= c_v;
            d2_v_reg <= d1_v_reg;
            d3_v_reg <= d2_v_reg;
            d4_v_reg <= d3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        psf_reg[0] <= s_c[1] * f_c[2];
        psf_reg[1] <= s_c[2] * f_c[1];
        psf_reg[2] <= s_c[2] * f_c[0];
        psf_reg[3] <= s_c[0] * f_c[2];
        psf_reg[4] <= s_c[0] * f_c[1];
        psf_reg[5] <= s_c[1] * f_c[0];
        for (int i = 0; i < 3; i++)
        begin
            pse_reg[i] <= s_c[i] * eye_c[i];
            pfe_reg[i] <= f_c[i] * eye_c[i];
            d2_u_reg[i] <= u_sum[i][FRAC_BITS +: UW];
            pue_reg[i] <= d2_u_reg[i] * d2_eye_reg[i];
        end
        d1_s_reg   <= s_c;
        d1_f_reg   <= f_c;
        d1_eye_reg <= eye_c;
        d1_deg_reg <= !c_sb[0] || !oks_c;

        d2_ds_reg  <= ds_sum[FRAC_BITS +: DOTW];
        d2_df_reg  <= df_sum[FRAC_BITS +: DOTW];
        d2_s_reg   <= d1_s_reg;
        d2_f_reg   <= d1_f_reg;
        d2_eye_reg <= d1_eye_reg;
        d2_deg_reg <= d1_deg_reg;

        d3_u_reg   <= d2_u_reg;
        d3_ds_reg  <= d2_ds_reg;
        d3_df_reg  <= d2_df_reg;
        d3_s_reg   <= d2_s_reg;
        d3_f_reg   <= d2_f_reg;
        d3_deg_reg <= d2_deg_reg;

        d4_du_reg  <= du_sum[FRAC_BITS +: DOTW];
        d4_u_reg   <= d3_u_reg;
        d4_ds_reg  <= d3_ds_reg;
        d4_df_reg  <= d3_df_reg;
        d4_s_reg   <= d3_s_reg;
        d4_f_reg   <= d3_f_reg;
        d4_deg_reg <= d3_deg_reg;
    end

    // row sequencer
    logic signed [COL_W-1:0] row0 [4];
    logic signed [COL_W-1:0] row1 [4];
    logic signed [COL_W-1:0] row2 [4];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            row0[i] = sat32(SAT_W'(d4_s_reg[i]));
            row1[i] = sat32(SAT_W'(d4_u_reg[i]));
            row2[i] = sat32(-SAT_W'(d4_f_reg[i]));
        end
        row0[3] = sat32(-SAT_W'(d4_ds_reg));
        row1[3] = sat32(-SAT_W'(d4_du_reg));
        row2[3] = sat32(SAT_W'(d4_df_reg));
    end

    logic signed [COL_W-1:0] buf1_reg [4];
    logic signed [COL_W-1:0] buf2_reg [4];
    logic                    deg_reg;
    logic                    act_reg;
    row_t                    nxt_reg;

    logic                    strobe_reg;
    row_t                    idx_reg;
    logic signed [COL_W-1:0] col_reg [4];
    logic                    odeg_reg;

    logic signed [COL_W-1:0] sel [4];

    always_comb
    begin
        unique case (nxt_reg)
            ROW_SIDE:  sel = buf1_reg;
            ROW_UP:    sel = buf1_reg;
            ROW_FWD:   sel = buf2_reg;
            ROW_CONST: sel = '{32'sd0, 32'sd0, 32'sd0, ONE};
            default:   sel = buf1_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            nxt_reg    <= ROW_SIDE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= d4_v_reg || act_reg;
            if (d4_v_reg)
            begin
                act_reg <= 1'b1;
                nxt_reg <= ROW_UP;
            end
            else if (act_reg)
            begin
                act_reg <= (nxt_reg != ROW_CONST);
                nxt_reg <= row_t'(nxt_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d4_v_reg)
        begin
            buf1_reg <= row1;
            buf2_reg <= row2;
            deg_reg  <= d4_deg_reg;
            col_reg  <= row0;
            idx_reg  <= ROW_SIDE;
            odeg_reg <= d4_deg_reg;
        end
        else if (act_reg)
        begin
            col_reg  <= sel;
            idx_reg  <= nxt_reg;
            odeg_reg <= deg_reg;
        end
    end

    assign row_strobe = strobe_reg;
    assign row_index  = idx_reg;
    assign col0       = col_reg[0];
    assign col1       = col_reg[1];
    assign col2       = col_reg[2];
    assign col3       = col_reg[3];
    assign degenerate = odeg_reg;
    assign row_last   = (idx_reg == ROW_CONST);

endmodule

// ===== hw/rtl/lavm_norm.sv =====
// Pipelined 3-vector normalizer: shift, sum of squares, square root, divide.
module lavm_norm import lavm_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int VW = 33,
    parameter int SBW = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [VW-1:0]        in_vec [3],
    input  logic [SBW-1:0]              in_sb,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] out_vec [3],
    output logic                        out_nz,
    output logic [SBW-1:0]              out_sb
);

    localparam int CW = FRAC_BITS + 2;
    localparam int NW = (VW > NORM_W) ? VW : NORM_W;
    localparam int LS = $clog2(NW);
    localparam int PBW = SBW + 4;
    localparam int QW = FRAC_BITS + 1;
    localparam int DVW = FRAC_BITS + ROOT_W;
    localparam int RMW = ROOT_W + 4;

    logic [VW-1:0]  mag [3];
    logic [2:0]     neg;

    logic [NW-1:0]  sh_m_reg [0:LS][3];
    logic [PBW-1:0] sh_p_reg [0:LS];
    logic           sh_v_reg [0:LS];

    logic [NORM_W-1:0]   sq_t_reg [3];
    logic [2*NORM_W-1:0] sq_reg [3];
    logic [PBW-1:0]      sq_p_reg;
    logic                sq_v_reg;

    logic [RMW-1:0]      rt_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   rt_root_reg [0:ROOT_W];
    logic [SUMSQ_W-1:0]  rt_n_reg    [0:ROOT_W];
    logic [NORM_W-1:0]   rt_t_reg    [0:ROOT_W][3];
    logic [PBW-1:0]      rt_p_reg    [0:ROOT_W];
    logic                rt_v_reg    [0:ROOT_W];

    logic [ROOT_W-1:0]   dv_r_reg   [0:QW][3];
    logic [DVW-1:0]      dv_d_reg   [0:QW][3];
    logic [QW-1:0]       dv_q_reg   [0:QW][3];
    logic [ROOT_W-1:0]   dv_nrm_reg [0:QW];
    logic [PBW-1:0]      dv_p_reg   [0:QW];
    logic                dv_v_reg   [0:QW];

    logic signed [CW-1:0] out_vec_reg [3];
    logic [PBW-1:0]       out_p_reg;
    logic                 out_v_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = in_vec[i][VW-1];
            mag[i] = neg[i] ? $unsigned(-in_vec[i]) : $unsigned(in_vec[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_v_reg[0] <= 1'b0;
        end
        else
        begin
            sh_v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh_m_reg[0][i] <= NW'(mag[i]);
        end
        sh_p_reg[0] <= {in_sb, |(mag[0] | mag[1] | mag[2]), neg};
    end

    for (genvar k = 0; k < LS; k++)
    begin : g_shift
        localparam int AMT = 1 << (LS - 1 - k);
        logic [NW-1:0] orw;
        logic          hit;
        logic [NW-1:0] sh_m_next [3];

        always_comb
        begin
            orw = sh_m_reg[k][0] | sh_m_reg[k][1] | sh_m_reg[k][2];
            hit = (orw[NW-1 -: AMT] == '0);
            for (int i = 0; i < 3; i++)
            begin
                sh_m_next[i] = hit ? (sh_m_reg[k][i] << AMT) : sh_m_reg[k][i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sh_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                sh_v_reg[k+1] <= sh_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sh_m_reg[k+1] <= sh_m_next;
            sh_p_reg[k+1] <= sh_p_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg    <= 1'b0;
            rt_v_reg[0] <= 1'b0;
        end
        else
        begin
            sq_v_reg    <= sh_v_reg[LS];
            rt_v_reg[0] <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_t_reg[i]    <= sh_m_reg[LS][i][NW-1 -: NORM_W];
            sq_reg[i]      <= sh_m_reg[LS][i][NW-1 -: NORM_W] * sh_m_reg[LS][i][NW-1 -: NORM_W];
            rt_t_reg[0][i] <= sq_t_reg[i];
        end
        sq_p_reg       <= sh_p_reg[LS];
        rt_n_reg[0]    <= SUMSQ_W'(sq_reg[0]) + SUMSQ_W'(sq_reg[1]) + SUMSQ_W'(sq_reg[2]);
        rt_rem_reg[0]  <= '0;
        rt_root_reg[0] <= '0;
        rt_p_reg[0]    <= sq_p_reg;
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_root
        logic [RMW-1:0]    rem_sh;
        logic [RMW-1:0]    trial;
        logic              ge;
        logic [RMW-1:0]    rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            rem_sh    = {rt_rem_reg[j][RMW-3:0], rt_n_reg[j][SUMSQ_W-1 -: 2]};
            trial     = RMW'({rt_root_reg[j], 2'b01});
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {rt_root_reg[j][ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_v_reg[j+1] <= 1'b0;
            end
            else
            begin
                rt_v_reg[j+1] <= rt_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rt_rem_reg[j+1]  <= rem_next;
            rt_root_reg[j+1] <= root_next;
            rt_n_reg[j+1]    <= {rt_n_reg[j][SUMSQ_W-3:0], 2'b00};
            rt_t_reg[j+1]    <= rt_t_reg[j];
            rt_p_reg[j+1]    <= rt_p_reg[j];
        end
    end

    logic [DVW-1:0] dv_d_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_d_next[i] = DVW'({rt_t_reg[ROOT_W][i], {FRAC_BITS{1'b0}}})
                         + DVW'(rt_root_reg[ROOT_W][ROOT_W-1:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            dv_v_reg[0] <= rt_v_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_d_reg[0][i] <= dv_d_next[i];
            dv_r_reg[0][i] <= ROOT_W'(dv_d_next[i][DVW-1:FRAC_BITS+1]);
            dv_q_reg[0][i] <= '0;
        end
        dv_nrm_reg[0] <= rt_root_reg[ROOT_W];
        dv_p_reg[0]   <= rt_p_reg[ROOT_W];
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int BIT = FRAC_BITS - k;
        logic [ROOT_W:0]   rsh [3];
        logic [2:0]        ge;
        logic [ROOT_W-1:0] r_next [3];
        logic [QW-1:0]     q_next [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsh[i]    = {dv_r_reg[k][i], dv_d_reg[k][i][BIT]};
                ge[i]     = (rsh[i] >= {1'b0, dv_nrm_reg[k]});
                r_next[i] = ge[i] ? ROOT_W'(rsh[i] - {1'b0, dv_nrm_reg[k]})
                                  : rsh[i][ROOT_W-1:0];
                q_next[i] = {dv_q_reg[k][i][QW-2:0], ge[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_r_reg[k+1]   <= r_next;
            dv_q_reg[k+1]   <= q_next;
            dv_d_reg[k+1]   <= dv_d_reg[k];
            dv_nrm_reg[k+1] <= dv_nrm_reg[k];
            dv_p_reg[k+1]   <= dv_p_reg[k];
        end
    end

    logic signed [CW-1:0] qs [3];
    logic signed [CW-1:0] out_vec_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = signed'(CW'(dv_q_reg[QW][i]));
            if (!dv_p_reg[QW][3])
            begin
                out_vec_next[i] = '0;
            end
            else if (dv_p_reg[QW][i])
            begin
                out_vec_next[i] = -qs[i];
            end
            else
            begin
                out_vec_next[i] = qs[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        out_vec_reg <= out_vec_next;
        out_p_reg   <= dv_p_reg[QW];
    end

    assign out_valid = out_v_reg;
    assign out_vec   = out_vec_reg;
    assign out_nz    = out_p_reg[3];
    assign out_sb    = out_p_reg[PBW-1:4];

endmodule

// ===== dv/tb_look_at_view_matrix.sv =====
// Self-checking testbench for the look-at view matrix block.
module tb_look_at_view_matrix;
    import lavm_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 2 * FRAC + 96;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
        logic               deg;
        logic               last;
    } view_row_t;

    typedef longint vec3_t [3];

    class view_matrix_scoreboard;
        view_row_t rows_due[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function automatic bit unit_vector(input vec3_t v, output vec3_t r);
            longint unsigned mag [3];
            longint unsigned mx;
            longint unsigned sum;
            longint unsigned nrm;
            longint c;
            int top;
            mx = 0;
            sum = 0;
            top = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
                if (mag[i] > mx)
                    mx = mag[i];
            end
            if (mx == 0)
            begin
                r[0] = 0; r[1] = 0; r[2] = 0;
                return 0;
            end
            while (top < 63 && (mx >> (top + 1)) != 0)
                top++;
            for (int i = 0; i < 3; i++)
            begin
                if (top > 30)
                    mag[i] >>= (top - 30);
                else
                    mag[i] <<= (30 - top);
                sum += mag[i] * mag[i];
            end
            nrm = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                c = longint'(((mag[i] << FRAC) + (nrm >> 1)) / nrm);
                r[i] = v[i] < 0 ? -c : c;
            end
            return 1;
        endfunction

        function automatic longint rounded_dot(input vec3_t a, input vec3_t e);
            longint hi;
            longint lo;
            longint p;
            longint h;
            hi = 0;
            lo = 0;
            for (int i = 0; i < 3; i++)
            begin
                p = a[i] * e[i];
                h = p >>> FRAC;
                hi += h;
                lo += p - (h <<< FRAC);
            end
            return hi + ((lo + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
        endfunction

        function automatic logic signed [31:0] clip32(longint x);
            if (x > 64'sd2147483647)
                return 32'sh7fffffff;
            if (x < -64'sd2147483648)
                return 32'sh80000000;
            return x[31:0];
        endfunction

        function automatic void push_row(logic [1:0] idx, longint a, longint b, longint c,
                                         longint t, bit deg);
            view_row_t r;
            r.idx = idx;
            r.c0 = clip32(a);
            r.c1 = clip32(b);
            r.c2 = clip32(c);
            r.c3 = clip32(t);
            r.deg = deg;
            r.last = (idx == ROW_CONST);
            rows_due.push_back(r);
        endfunction

        function automatic void note_camera(input logic signed [31:0] in_v [9]);
            vec3_t eye, fw, upv, f, u0, sr, s, u;
            bit okf, oks, deg;
            for (int i = 0; i < 3; i++)
            begin
                eye[i] = longint'(in_v[i]);
                fw[i] = longint'(in_v[3 + i]) - eye[i];
                upv[i] = longint'(in_v[6 + i]);
            end
            okf = unit_vector(fw, f);
            void'(unit_vector(upv, u0));
            sr[0] = f[1] * u0[2] - f[2] * u0[1];
            sr[1] = f[2] * u0[0] - f[0] * u0[2];
            sr[2] = f[0] * u0[1] - f[1] * u0[0];
            oks = unit_vector(sr, s);
            u[0] = (s[1] * f[2] - s[2] * f[1] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            u[1] = (s[2] * f[0] - s[0] * f[2] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            u[2] = (s[0] * f[1] - s[1] * f[0] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            deg = !okf || !oks;
            push_row(ROW_SIDE, s[0], s[1], s[2], -rounded_dot(s, eye), deg);
            push_row(ROW_UP, u[0], u[1], u[2], -rounded_dot(u, eye), deg);
            push_row(ROW_FWD, -f[0], -f[1], -f[2], rounded_dot(f, eye), deg);
            push_row(ROW_CONST, 0, 0, 0, 64'sd1 <<< FRAC, deg);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_row(view_row_t got);
            view_row_t want;
            if (rows_due.size() == 0)
            begin
                report($sformatf("unexpected row %0d", got.idx));
                return;
            end
            want = rows_due.pop_front();
            if (got.idx !== want.idx)
                report($sformatf("row_index %0d, want %0d", got.idx, want.idx));
            if (got.c0 !== want.c0)
                report($sformatf("row %0d col0 %h, want %h", want.idx, got.c0, want.c0));
            if (got.c1 !== want.c1)
                report($sformatf("row %0d col1 %h, want %h", want.idx, got.c1, want.c1));
            if (got.c2 !== want.c2)
                report($sformatf("row %0d col2 %h, want %h", want.idx, got.c2, want.c2));
            if (got.c3 !== want.c3)
                report($sformatf("row %0d col3 %h, want %h", want.idx, got.c3, want.c3));
            if (got.deg !== want.deg)
                report($sformatf("row %0d degenerate %b, want %b", want.idx, got.deg, want.deg));
            if (got.last !== want.last)
                report($sformatf("row %0d row_last %b, want %b", want.idx, got.last, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] cam [9];
    logic row_strobe;
    logic [1:0] row_index;
    logic signed [31:0] col0, col1, col2, col3;
    logic degenerate;
    logic row_last;
    int cycles;
    bit quiet;
    view_matrix_scoreboard sb;

    look_at_view_matrix #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .eye_x(cam[0]), .eye_y(cam[1]), .eye_z(cam[2]),
        .focus_x(cam[3]), .focus_y(cam[4]), .focus_z(cam[5]),
        .up_x(cam[6]), .up_y(cam[7]), .up_z(cam[8]),
        .row_strobe(row_strobe), .row_index(row_index),
        .col0(col0), .col1(col1), .col2(col2), .col3(col3),
        .degenerate(degenerate), .row_last(row_last)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        view_row_t got;
        if (rst_n && row_strobe)
        begin
            got.idx = row_index;
            got.c0 = col0;
            got.c1 = col1;
            got.c2 = col2;
            got.c3 = col3;
            got.deg = degenerate;
            got.last = row_last;
            sb.check_row(got);
        end
    end

    task send_camera(input logic signed [31:0] v [9]);
        bit done;
        while (!quiet && $urandom_range(99) < 11)
        begin
            start = 0;
            @(negedge clk);
        end
        cam = v;
        start = 1;
        done = 0;
        while (!done)
        begin
            @(posedge clk);
            if (!busy)
            begin
                sb.note_camera(v);
                done = 1;
            end
            @(negedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(200 << 16)) - (100 << 16);
            default: return $signed($urandom_range(64)) - 32;
        endcase
    endfunction

    task send_random();
        logic signed [31:0] v [9];
        int mode;
        int kind;
        mode = $urandom_range(2);
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++)
            v[i] = rand_coord(mode);
        if (kind == 0)
            for (int i = 0; i < 3; i++)
                v[3 + i] = v[i];
        else if (kind == 1)
            for (int i = 0; i < 3; i++)
                v[6 + i] = (v[3 + i] - v[i]) * 2;
        else if (kind == 2)
            v[6 + $urandom_range(2)] = 0;
        else if (kind == 3)
            for (int i = 0; i < 3; i++)
                v[6 + i] = 0;
        send_camera(v);
    endtask

    initial
    begin
        logic signed [31:0] v [9];
        sb = new();
        cycles = 0;
        quiet = 0;
        start = 0;
        for (int i = 0; i < 9; i++)
            cam[i] = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        v = '{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0};
        send_camera(v);
        v = '{1 << 16, 2 << 16, 3 << 16, 1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0};
        send_camera(v);
        v = '{0, 0, 0, 0, 0, -(1 << 16), 0, 0, 0};
        send_camera(v);
        v = '{0, 0, 0, 0, 3 << 16, 0, 0, 7 << 16, 0};
        send_camera(v);
        v = '{0, 0, 0, 1 << 16, 0, 0, 2, 1 << 16, 0};
        send_camera(v);
        v = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        send_camera(v);
        v = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        send_camera(v);
        v = '{32'sh80000000, 0, 0, 32'sh7fffffff, 1, 0, 0, 0, 32'sh80000000};
        send_camera(v);
        v = '{32'sh7fffffff, 32'sh80000000, 0, 0, 0, 32'sh7fffffff, 1, 1, 1};
        send_camera(v);
        v = '{1, -1, 1, -1, 1, -1, -1, -1, -1};
        send_camera(v);
        v = '{-1, -1, -1, -1, -1, -1, 1, 0, 0};
        send_camera(v);
        v = '{100 << 16, -50 << 16, 25 << 16, 0, 0, 0, 0, 0, 1 << 16};
        send_camera(v);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 150 && n < 260);
            send_random();
        end
        start = 0;

        while (sb.rows_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
